### hw/rtl/buffer_slot_pool_manager_core_assert.svh
// Assertion macros for the buffer slot pool manager.
// Included by the RTL modules that carry concurrent assertions.
`ifndef BUFFER_SLOT_POOL_MANAGER_CORE_ASSERT_SVH
`define BUFFER_SLOT_POOL_MANAGER_CORE_ASSERT_SVH

// Property must hold at every edge outside reset.
`define BSPM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("bspm assertion failed");

// Expression must never be true outside reset.
`define BSPM_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("bspm forbidden condition seen");

`endif

### hw/rtl/bspm_pkg.sv
// Shared types and constants for the buffer slot pool manager.
// No dependencies.
`default_nettype none

package bspm_pkg;

  localparam int unsigned SLOT_CAP    = 8;
  localparam int unsigned SLOT_W      = 3;
  localparam int unsigned NUM_ID_REGS = 3;
  localparam int unsigned ID_W        = 32;
  localparam int unsigned OPC_W       = 16;
  localparam int unsigned SIZE_W      = 16;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned NF_OUT_W    = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [SIZE_W-1:0] HEADER_SIZE = 16'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOT0_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT1_ID = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT2_ID = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REL_OPC  = 2'd3;

  localparam logic ACT_COMMIT  = 1'b0;
  localparam logic ACT_MESSAGE = 1'b1;

  typedef enum logic [1:0] {
    BSP_IDLE,
    BSP_REL,
    BSP_FREE,
    BSP_DONE
  } bsp_state_e;

endpackage

`default_nettype wire

### hw/rtl/buffer_slot_pool_manager_core.sv
// Buffer slot pool manager: round-robin slot pool with release event matching.
// Depends on bspm_pkg and buffer_slot_pool_manager_core_assert.svh.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one beat per item: a commit
//   of a slot or one decoded event header. Output channel (out_valid_o /
//   out_stall_i) returns exactly one result beat per input beat, in order.
//   Configuration is a write-only port (cfg_we_i, cfg_idx_i, cfg_wdata_i),
//   written while the block is idle.
//   Timing: the accept cycle applies a commit, then a sequencer walks the slots
//   one per cycle with a single compare unit. A release event scans 1 to
//   SLOT_COUNT slots for a matching busy buffer id, then every item scans 1 to
//   SLOT_COUNT slots from the pointer for the next free one. in_stall_o stays
//   high from accept to result, so one item is in flight at a time.
//   The result sits in an output register; a new item may be accepted while
//   it waits. If the receiver stalls, the finished item after that holds in
//   its last state until the output register drains.
//   Reset clears all slots, the pointer, the dead-batch flag, both counters
//   and the configuration registers.
`default_nettype none

module buffer_slot_pool_manager_core #(
  parameter int unsigned SLOT_COUNT = 3
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire  [bspm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire  [bspm_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire                                 action_i,
  input  wire  [bspm_pkg::SLOT_W-1:0]         slot_i,
  input  wire  [bspm_pkg::ID_W-1:0]           evt_obj_i,
  input  wire  [bspm_pkg::OPC_W-1:0]          opcode_i,
  input  wire  [bspm_pkg::SIZE_W-1:0]         msg_size_i,
  input  wire                                 batch_start_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic                                accepted_o,
  output logic                                released_o,
  output logic [bspm_pkg::NF_OUT_W-1:0]       next_free_o,
  output logic [bspm_pkg::CNT_W-1:0]          frame_total_o,
  output logic [bspm_pkg::CNT_W-1:0]          release_total_o
);

  `include "buffer_slot_pool_manager_core_assert.svh"

  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned NF_W  = $clog2(SLOT_COUNT + 1);
  localparam int unsigned PAD_N = 2 ** IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  // configuration
  logic [bspm_pkg::ID_W-1:0]  id0_q, id1_q, id2_q;
  logic [bspm_pkg::OPC_W-1:0] opc_q;

  // state
  bspm_pkg::bsp_state_e state_q, state_d;
  logic [SLOT_COUNT-1:0]      busy_q, busy_d;
  logic [IDX_W-1:0]           ptr_q, ptr_d;
  logic                       dead_q, dead_d;
  logic [bspm_pkg::CNT_W-1:0] frame_q, frame_d;
  logic [bspm_pkg::CNT_W-1:0] relc_q, relc_d;
  logic [IDX_W-1:0]           idx_q, idx_d;
  logic [IDX_W-1:0]           cnt_q, cnt_d;
  logic [bspm_pkg::ID_W-1:0]  obj_q, obj_d;
  logic                       acc_q, acc_d;
  logic                       rel_q, rel_d;
  logic [NF_W-1:0]            nf_q, nf_d;

  // output register
  logic                       ovld_q, ovld_d;
  logic                       oacc_q, oacc_d;
  logic                       orel_q, orel_d;
  logic [bspm_pkg::NF_OUT_W-1:0] onf_q, onf_d;
  logic [bspm_pkg::CNT_W-1:0] ofr_q, ofr_d;
  logic [bspm_pkg::CNT_W-1:0] orc_q, orc_d;

  // decode and shared compare unit
  logic                       in_acc;
  logic [bspm_pkg::SLOT_CAP-1:0] busy8;
  logic [PAD_N-1:0]           busy_pad;
  logic                       commit_ok;
  logic                       dead_tmp;
  logic                       msg_ok;
  logic                       rel_req;
  logic [2:0]                 idx3;
  logic [bspm_pkg::ID_W-1:0]  cur_id;
  logic                       id_en;
  logic                       cur_busy;
  logic                       hit;
  logic [IDX_W-1:0]           idx_nxt;
  logic                       out_free;
  logic                       rel_fire;
  logic                       nf_hold;
  logic                       commit_acc;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !ovld_q || !out_stall_i;

  always_comb begin
    busy8 = '0;
    busy8[SLOT_COUNT-1:0] = busy_q;
    busy_pad = '0;
    busy_pad[SLOT_COUNT-1:0] = busy_q;
  end

  always_comb begin
    commit_ok = (action_i == bspm_pkg::ACT_COMMIT) &&
                (slot_i < bspm_pkg::SLOT_W'(SLOT_COUNT)) && !busy8[slot_i];
    dead_tmp  = batch_start_i ? 1'b0 : dead_q;
    msg_ok    = (action_i == bspm_pkg::ACT_MESSAGE) && !dead_tmp &&
                (msg_size_i == bspm_pkg::HEADER_SIZE);
    rel_req   = msg_ok && (opcode_i == opc_q);
  end

  always_comb begin
    idx3 = 3'(idx_q);
    case (idx3)
      3'd0: begin
        cur_id = id0_q;
        id_en  = 1'b1;
      end
      3'd1: begin
        cur_id = id1_q;
        id_en  = 1'b1;
      end
      3'd2: begin
        cur_id = id2_q;
        id_en  = 1'b1;
      end
      default: begin
        cur_id = '0;
        id_en  = 1'b0;
      end
    endcase
    cur_busy = busy_pad[idx_q];
    hit      = cur_busy && id_en && (cur_id == obj_q);
    idx_nxt  = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bspm_pkg::BSP_IDLE: begin
        if (in_acc) begin
          state_d = rel_req ? bspm_pkg::BSP_REL : bspm_pkg::BSP_FREE;
        end
      end
      bspm_pkg::BSP_REL: begin
        if (hit || idx_q == LAST_IDX) begin
          state_d = bspm_pkg::BSP_FREE;
        end
      end
      bspm_pkg::BSP_FREE: begin
        if (!cur_busy || cnt_q == LAST_IDX) begin
          state_d = bspm_pkg::BSP_DONE;
        end
      end
      bspm_pkg::BSP_DONE: begin
        if (out_free) begin
          state_d = bspm_pkg::BSP_IDLE;
        end
      end
      default: state_d = bspm_pkg::BSP_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    in_stall_o = (state_q != bspm_pkg::BSP_IDLE);
    busy_d  = busy_q;
    ptr_d   = ptr_q;
    dead_d  = dead_q;
    frame_d = frame_q;
    relc_d  = relc_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    obj_d   = obj_q;
    acc_d   = acc_q;
    rel_d   = rel_q;
    nf_d    = nf_q;
    ovld_d  = ovld_q;
    oacc_d  = oacc_q;
    orel_d  = orel_q;
    onf_d   = onf_q;
    ofr_d   = ofr_q;
    orc_d   = orc_q;

    if (ovld_q && !out_stall_i) begin
      ovld_d = 1'b0;
    end

    unique case (state_q)
      bspm_pkg::BSP_IDLE: begin
        if (in_acc) begin
          obj_d = evt_obj_i;
          rel_d = 1'b0;
          cnt_d = '0;
          if (action_i == bspm_pkg::ACT_COMMIT) begin
            acc_d = commit_ok;
            if (commit_ok) begin
              for (int k = 0; k < SLOT_COUNT; k++) begin
                if (bspm_pkg::SLOT_W'(k) == slot_i) begin
                  busy_d[k] = 1'b1;
                end
              end
              ptr_d   = (slot_i == bspm_pkg::SLOT_W'(SLOT_COUNT - 1)) ? '0 :
                        IDX_W'(slot_i + 3'd1);
              frame_d = frame_q + 1'b1;
              idx_d   = (slot_i == bspm_pkg::SLOT_W'(SLOT_COUNT - 1)) ? '0 :
                        IDX_W'(slot_i + 3'd1);
            end else begin
              idx_d = ptr_q;
            end
          end else begin
            acc_d  = msg_ok;
            dead_d = dead_tmp || (!dead_tmp && (msg_size_i != bspm_pkg::HEADER_SIZE));
            idx_d  = rel_req ? '0 : ptr_q;
          end
        end
      end
      bspm_pkg::BSP_REL: begin
        if (hit) begin
          for (int k = 0; k < SLOT_COUNT; k++) begin
            if (IDX_W'(k) == idx_q) begin
              busy_d[k] = 1'b0;
            end
          end
          relc_d = relc_q + 1'b1;
          rel_d  = 1'b1;
        end
        if (hit || idx_q == LAST_IDX) begin
          idx_d = ptr_q;
          cnt_d = '0;
        end else begin
          idx_d = idx_nxt;
        end
      end
      bspm_pkg::BSP_FREE: begin
        if (!cur_busy) begin
          nf_d = NF_W'(idx_q);
        end else if (cnt_q == LAST_IDX) begin
          nf_d = NF_W'(SLOT_COUNT);
        end else begin
          idx_d = idx_nxt;
          cnt_d = cnt_q + 1'b1;
        end
      end
      bspm_pkg::BSP_DONE: begin
        if (out_free) begin
          ovld_d = 1'b1;
          oacc_d = acc_q;
          orel_d = rel_q;
          onf_d  = nf_q[bspm_pkg::NF_OUT_W-1:0];
          ofr_d  = frame_q;
          orc_d  = relc_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id0_q <= '0;
      id1_q <= '0;
      id2_q <= '0;
      opc_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bspm_pkg::CFG_SLOT0_ID: id0_q <= cfg_wdata_i;
        bspm_pkg::CFG_SLOT1_ID: id1_q <= cfg_wdata_i;
        bspm_pkg::CFG_SLOT2_ID: id2_q <= cfg_wdata_i;
        bspm_pkg::CFG_REL_OPC:  opc_q <= cfg_wdata_i[bspm_pkg::OPC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bspm_pkg::BSP_IDLE;
      busy_q  <= '0;
      ptr_q   <= '0;
      dead_q  <= 1'b0;
      frame_q <= '0;
      relc_q  <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
      ptr_q   <= ptr_d;
      dead_q  <= dead_d;
      frame_q <= frame_d;
      relc_q  <= relc_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    cnt_q <= cnt_d;
    obj_q <= obj_d;
    acc_q <= acc_d;
    rel_q <= rel_d;
    nf_q  <= nf_d;
    oacc_q <= oacc_d;
    orel_q <= orel_d;
    onf_q  <= onf_d;
    ofr_q  <= ofr_d;
    orc_q  <= orc_d;
  end

  assign out_valid_o     = ovld_q;
  assign accepted_o      = oacc_q;
  assign released_o      = orel_q;
  assign next_free_o     = onf_q;
  assign frame_total_o   = ofr_q;
  assign release_total_o = orc_q;

  assign rel_fire   = (state_q == bspm_pkg::BSP_REL) && hit;
  assign nf_hold    = (state_q == bspm_pkg::BSP_DONE) && (nf_q < NF_W'(SLOT_COUNT));
  assign commit_acc = in_acc && (action_i == bspm_pkg::ACT_COMMIT);

  `BSPM_ASSERT_NEVER(a_rel_without_acc, clk_i, rst_ni, out_valid_o && released_o && !accepted_o)
  `BSPM_ASSERT(a_rel_count, clk_i, rst_ni, rel_fire |=> (relc_q == $past(relc_q) + 1'b1))
  `BSPM_ASSERT(a_nf_is_free, clk_i, rst_ni, nf_hold |-> !busy_pad[nf_q[IDX_W-1:0]])
  `BSPM_ASSERT(a_frame_on_commit, clk_i, rst_ni, (frame_q != $past(frame_q)) |-> $past(commit_acc))

endmodule

`default_nettype wire

### sim/bspm_checker.sv
// Scoreboard for buffer_slot_pool_manager_core: tracks config writes, predicts
// one result per accepted item beat and compares result beats in order.
// Depends on bspm_pkg.
module bspm_checker #(
  parameter int unsigned SLOT_COUNT = 3
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire  [bspm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire  [bspm_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  wire                                 in_valid_i,
  input  wire                                 in_stall_i,
  input  wire                                 action_i,
  input  wire  [bspm_pkg::SLOT_W-1:0]         slot_i,
  input  wire  [bspm_pkg::ID_W-1:0]           evt_obj_i,
  input  wire  [bspm_pkg::OPC_W-1:0]          opcode_i,
  input  wire  [bspm_pkg::SIZE_W-1:0]         msg_size_i,
  input  wire                                 batch_start_i,
  input  wire                                 out_valid_i,
  input  wire                                 out_stall_i,
  input  wire                                 accepted_i,
  input  wire                                 released_i,
  input  wire  [bspm_pkg::NF_OUT_W-1:0]       next_free_i,
  input  wire  [bspm_pkg::CNT_W-1:0]          frame_total_i,
  input  wire  [bspm_pkg::CNT_W-1:0]          release_total_i,
  output int unsigned                         fail_count_o,
  output int unsigned                         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                          accepted;
    logic                          released;
    logic [bspm_pkg::NF_OUT_W-1:0] next_free;
    logic [bspm_pkg::CNT_W-1:0]    frame_total;
    logic [bspm_pkg::CNT_W-1:0]    release_total;
  } pool_result_t;

  logic [bspm_pkg::ID_W-1:0]  buf_id [bspm_pkg::NUM_ID_REGS];
  logic [bspm_pkg::OPC_W-1:0] rel_opc;
  logic                       slot_busy [bspm_pkg::SLOT_CAP];
  int unsigned                rr_ptr;
  logic                       batch_dead;
  logic [bspm_pkg::CNT_W-1:0] frames;
  logic [bspm_pkg::CNT_W-1:0] releases;
  int unsigned                mismatches = 0;
  pool_result_t               due_results_q [$];

  function automatic pool_result_t predict_pool_result(
    logic act, logic [bspm_pkg::SLOT_W-1:0] slot, logic [bspm_pkg::ID_W-1:0] oid,
    logic [bspm_pkg::OPC_W-1:0] opc, logic [bspm_pkg::SIZE_W-1:0] size, logic bstart);
    pool_result_t r;
    logic         hit;
    int unsigned  nf;
    int unsigned  idx;
    r   = '0;
    hit = 1'b0;
    nf  = SLOT_COUNT;
    if (act == bspm_pkg::ACT_COMMIT) begin
      if (slot < SLOT_COUNT && !slot_busy[slot]) begin
        slot_busy[slot] = 1'b1;
        rr_ptr = (slot + 1) % SLOT_COUNT;
        frames = frames + 1'b1;
        r.accepted = 1'b1;
      end
    end else begin
      if (bstart) batch_dead = 1'b0;
      if (!batch_dead) begin
        if (size != bspm_pkg::HEADER_SIZE) begin
          batch_dead = 1'b1;
        end else begin
          r.accepted = 1'b1;
          if (opc == rel_opc) begin
            // lowest busy slot with a matching id wins
            for (int unsigned i = 0; i < SLOT_COUNT; i++) begin
              if (!hit && i < bspm_pkg::NUM_ID_REGS && slot_busy[i] &&
                  buf_id[i] == oid) begin
                slot_busy[i] = 1'b0;
                releases = releases + 1'b1;
                hit = 1'b1;
              end
            end
          end
        end
      end
    end
    for (int unsigned i = 0; i < SLOT_COUNT; i++) begin
      idx = (rr_ptr + i) % SLOT_COUNT;
      if (nf == SLOT_COUNT && !slot_busy[idx]) nf = idx;
    end
    r.released      = hit;
    r.next_free     = bspm_pkg::NF_OUT_W'(nf);
    r.frame_total   = frames;
    r.release_total = releases;
    return r;
  endfunction

  task automatic check_field(string name, logic [bspm_pkg::CNT_W-1:0] want,
                             logic [bspm_pkg::CNT_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pool_result_t want;
    if (!rst_ni) begin
      buf_id     = '{default: '0};
      rel_opc    = '0;
      slot_busy  = '{default: 1'b0};
      rr_ptr     = 0;
      batch_dead = 1'b0;
      frames     = '0;
      releases   = '0;
      due_results_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bspm_pkg::CFG_SLOT0_ID: buf_id[0] = cfg_wdata_i;
          bspm_pkg::CFG_SLOT1_ID: buf_id[1] = cfg_wdata_i;
          bspm_pkg::CFG_SLOT2_ID: buf_id[2] = cfg_wdata_i;
          bspm_pkg::CFG_REL_OPC:  rel_opc   = cfg_wdata_i[bspm_pkg::OPC_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (due_results_q.size() == 0) begin
          $error("result beat with no item outstanding");
          mismatches++;
        end else begin
          want = due_results_q.pop_front();
          check_field("accepted", bspm_pkg::CNT_W'(want.accepted),
                      bspm_pkg::CNT_W'(accepted_i));
          check_field("released", bspm_pkg::CNT_W'(want.released),
                      bspm_pkg::CNT_W'(released_i));
          check_field("next_free", bspm_pkg::CNT_W'(want.next_free),
                      bspm_pkg::CNT_W'(next_free_i));
          check_field("frame_total", want.frame_total, frame_total_i);
          check_field("release_total", want.release_total, release_total_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        due_results_q.push_back(predict_pool_result(action_i, slot_i, evt_obj_i,
                                                    opcode_i, msg_size_i, batch_start_i));
      end
    end
    pending_o    <= due_results_q.size();
    fail_count_o <= mismatches;
  end

endmodule

### sim/tb.sv
// Top of the testbench for buffer_slot_pool_manager_core: clock, reset, config
// phases, directed and random item beats, result stalls, watchdog and verdict.
// Depends on bspm_pkg, buffer_slot_pool_manager_core and bspm_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS       = 3;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS = 300;
  localparam int unsigned LONG_HOLD   = 400;

  logic                            clk_i;
  logic                            rst_ni      = 1'b0;
  logic                            cfg_we      = 1'b0;
  logic [bspm_pkg::CFG_IDX_W-1:0]  cfg_idx     = bspm_pkg::CFG_SLOT0_ID;
  logic [bspm_pkg::CFG_DATA_W-1:0] cfg_wdata   = '0;
  logic                            in_valid    = 1'b0;
  logic                            in_stall;
  logic                            action      = bspm_pkg::ACT_COMMIT;
  logic [bspm_pkg::SLOT_W-1:0]     slot        = '0;
  logic [bspm_pkg::ID_W-1:0]       evt_obj     = '0;
  logic [bspm_pkg::OPC_W-1:0]      opcode      = '0;
  logic [bspm_pkg::SIZE_W-1:0]     msg_size    = '0;
  logic                            batch_start = 1'b0;
  logic                            out_valid;
  logic                            out_stall   = 1'b0;
  logic                            accepted;
  logic                            released;
  logic [bspm_pkg::NF_OUT_W-1:0]   next_free;
  logic [bspm_pkg::CNT_W-1:0]      frame_total;
  logic [bspm_pkg::CNT_W-1:0]      release_total;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles  = 0;
  int unsigned tx_calm      = 0;
  int unsigned rx_calm      = 0;
  int unsigned results_seen = 0;

  logic [bspm_pkg::ID_W-1:0]  cur_id [bspm_pkg::NUM_ID_REGS] = '{default: '0};
  logic [bspm_pkg::OPC_W-1:0] cur_opc = '0;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  buffer_slot_pool_manager_core #(.SLOT_COUNT(SLOTS)) u_dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .action_i(action), .slot_i(slot), .evt_obj_i(evt_obj),
    .opcode_i(opcode), .msg_size_i(msg_size), .batch_start_i(batch_start),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .accepted_o(accepted), .released_o(released), .next_free_o(next_free),
    .frame_total_o(frame_total), .release_total_o(release_total)
  );

  bspm_checker #(.SLOT_COUNT(SLOTS)) u_checker (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .action_i(action), .slot_i(slot), .evt_obj_i(evt_obj),
    .opcode_i(opcode), .msg_size_i(msg_size), .batch_start_i(batch_start),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .accepted_i(accepted), .released_i(released), .next_free_i(next_free),
    .frame_total_i(frame_total), .release_total_i(release_total),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  task automatic write_config(logic [bspm_pkg::ID_W-1:0] id0, logic [bspm_pkg::ID_W-1:0] id1,
                              logic [bspm_pkg::ID_W-1:0] id2,
                              logic [bspm_pkg::OPC_W-1:0] opc);
    cfg_we    <= 1'b1;
    cfg_idx   <= bspm_pkg::CFG_SLOT0_ID;
    cfg_wdata <= id0;
    @(posedge clk_i);
    cfg_idx   <= bspm_pkg::CFG_SLOT1_ID;
    cfg_wdata <= id1;
    @(posedge clk_i);
    cfg_idx   <= bspm_pkg::CFG_SLOT2_ID;
    cfg_wdata <= id2;
    @(posedge clk_i);
    cfg_idx   <= bspm_pkg::CFG_REL_OPC;
    cfg_wdata <= bspm_pkg::CFG_DATA_W'(opc);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cur_id  = '{id0, id1, id2};
    cur_opc = opc;
  endtask

  // drop valid and wait for every outstanding result beat
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic send_item(logic act, logic [bspm_pkg::SLOT_W-1:0] s,
                           logic [bspm_pkg::ID_W-1:0] oid, logic [bspm_pkg::OPC_W-1:0] opc,
                           logic [bspm_pkg::SIZE_W-1:0] size, logic bstart);
    int unsigned gap;
    if (tx_calm > 0) begin
      tx_calm--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 24) == 0) tx_calm = $urandom_range(10, 40);
      gap = $urandom_range(0, 16);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    action      <= act;
    slot        <= s;
    evt_obj     <= oid;
    opcode      <= opc;
    msg_size    <= size;
    batch_start <= bstart;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic send_random();
    logic                        act;
    logic [bspm_pkg::SLOT_W-1:0] s;
    logic [bspm_pkg::ID_W-1:0]   oid;
    logic [bspm_pkg::OPC_W-1:0]  opc;
    logic [bspm_pkg::SIZE_W-1:0] size;
    logic                        bstart;
    act = ($urandom_range(0, 99) < 45) ? bspm_pkg::ACT_COMMIT : bspm_pkg::ACT_MESSAGE;
    s = ($urandom_range(0, 9) == 0) ? bspm_pkg::SLOT_W'($urandom_range(0, 7))
                                    : bspm_pkg::SLOT_W'($urandom_range(0, SLOTS - 1));
    oid = ($urandom_range(0, 3) != 0) ? cur_id[$urandom_range(0, bspm_pkg::NUM_ID_REGS - 1)]
                                      : bspm_pkg::ID_W'($urandom);
    opc = ($urandom_range(0, 3) != 0) ? cur_opc : bspm_pkg::OPC_W'($urandom);
    case ($urandom_range(0, 19))
      0:       size = '0;
      1:       size = '1;
      2, 3:    size = bspm_pkg::SIZE_W'($urandom);
      default: size = bspm_pkg::HEADER_SIZE;
    endcase
    bstart = ($urandom_range(0, 3) == 0);
    send_item(act, s, oid, opc, size, bstart);
  endtask

  // result side: random stalls, two long hold-offs to back the block up
  initial begin
    int unsigned hold;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (results_seen == 250 || results_seen == 870) begin
        hold = LONG_HOLD;
      end else if (rx_calm > 0) begin
        rx_calm--;
        hold = 0;
      end else begin
        if ($urandom_range(0, 24) == 0) rx_calm = $urandom_range(10, 40);
        hold = $urandom_range(0, 16);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: all ids and the release opcode are zero
    send_item(bspm_pkg::ACT_COMMIT, 3'd0, '0, '0, '0, 1'b0);
    send_item(bspm_pkg::ACT_MESSAGE, 3'd0, '0, '0, bspm_pkg::HEADER_SIZE, 1'b1);
    drain();

    write_config('0, '1, 32'd5, '1);
    send_item(bspm_pkg::ACT_COMMIT, 3'd7, '1, '1, '1, 1'b1);
    send_item(bspm_pkg::ACT_COMMIT, 3'd3, '0, '0, '0, 1'b0);
    send_item(bspm_pkg::ACT_COMMIT, 3'd2, '0, '0, '0, 1'b0);
    send_item(bspm_pkg::ACT_COMMIT, 3'd2, '0, '0, '0, 1'b0);
    send_item(bspm_pkg::ACT_COMMIT, 3'd0, '0, '0, '0, 1'b0);
    send_item(bspm_pkg::ACT_COMMIT, 3'd1, '0, '0, '0, 1'b0);
    send_item(bspm_pkg::ACT_MESSAGE, 3'd0, '1, '1, bspm_pkg::HEADER_SIZE, 1'b1);
    send_item(bspm_pkg::ACT_MESSAGE, 3'd7, '0, 16'hFFFE, bspm_pkg::HEADER_SIZE, 1'b0);
    send_item(bspm_pkg::ACT_MESSAGE, 3'd0, 32'd12345, '1, bspm_pkg::HEADER_SIZE, 1'b0);
    send_item(bspm_pkg::ACT_MESSAGE, 3'd0, '0, '1, 16'd9, 1'b0);
    send_item(bspm_pkg::ACT_MESSAGE, 3'd0, '0, '1, bspm_pkg::HEADER_SIZE, 1'b0);
    send_item(bspm_pkg::ACT_COMMIT, 3'd1, '0, '0, '0, 1'b0);
    send_item(bspm_pkg::ACT_MESSAGE, 3'd0, '0, '1, bspm_pkg::HEADER_SIZE, 1'b0);
    send_item(bspm_pkg::ACT_MESSAGE, 3'd0, '0, '1, bspm_pkg::HEADER_SIZE, 1'b1);
    send_item(bspm_pkg::ACT_MESSAGE, 3'd0, '0, '1, '1, 1'b1);
    send_item(bspm_pkg::ACT_MESSAGE, 3'd0, 32'd5, '1, '0, 1'b1);
    send_item(bspm_pkg::ACT_MESSAGE, 3'd0, 32'd5, '1, bspm_pkg::HEADER_SIZE, 1'b1);
    send_item(bspm_pkg::ACT_COMMIT, 3'd0, '0, '0, '0, 1'b0);
    send_item(bspm_pkg::ACT_COMMIT, 3'd6, '0, '0, '0, 1'b0);
    drain();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       write_config(bspm_pkg::ID_W'($urandom), bspm_pkg::ID_W'($urandom),
                              bspm_pkg::ID_W'($urandom), bspm_pkg::OPC_W'($urandom));
        1:       write_config(32'd7, 32'd7, 32'd7, '0);
        2:       write_config('1, '1, '0, '1);
        3:       write_config(bspm_pkg::ID_W'($urandom_range(0, 2)),
                              bspm_pkg::ID_W'($urandom_range(0, 2)),
                              bspm_pkg::ID_W'($urandom_range(0, 2)), bspm_pkg::HEADER_SIZE);
        default: write_config(bspm_pkg::ID_W'($urandom), '0, bspm_pkg::ID_W'($urandom),
                              bspm_pkg::OPC_W'($urandom));
      endcase
      for (int k = 1; k <= PHASE_ITEMS; k++) begin
        send_random();
        if (k % 100 == 0) drain();
      end
    end

    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
